// File: sv/ptct_pkg.sv
`timescale 1ns / 1ps
package ptct_pkg;

	// Field widths
	localparam int COUNT_W = 64;
	localparam int PERIOD_W = 32;
	localparam int TICK_W = 32;
	// Dividend bits: a positive difference never has its sign bit set
	localparam int DVD_W = COUNT_W - 1;
	localparam int CNT_W = $clog2(DVD_W);

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_ENABLE = 1'b1;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000000;

	// Function codes
	localparam logic FUNC_ARM = 1'b0;
	localparam logic FUNC_POLL = 1'b1;

	// What the current request turned out to be
	typedef enum logic [1:0] {
		K_ARM,
		K_NONE,
		K_ZERO,
		K_DIV
	} kind_t;

	typedef struct packed {
		logic func;
		logic [COUNT_W-1:0] count_sample;
	} req_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_count;
		logic tick_saturated;
		logic [COUNT_W-1:0] next_compare;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic eval;
		logic div_step;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic divide;
		logic div_last;
	} status_t;

endpackage

// File: sv/ptct_ctrl.sv
`timescale 1ns / 1ps
module ptct_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  ptct_pkg::status_t status,
	output ptct_pkg::cmd_t cmd
);
	import ptct_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;
	logic rsp_valid_q;
	logic slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.capture = req_valid;
			S_EVAL: cmd.eval = 1'b1;
			S_DIV:  cmd.div_step = status.divide;
			S_DONE: cmd.finish = slot_free;
			default: cmd = '0;
		endcase
	end

	// Sequence one request at a time and hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_EVAL;
				end
				S_EVAL: state_q <= S_DIV;
				S_DIV: begin
					if (!status.divide || status.div_last) state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	a_finish_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp_valid)
		else $error("finished result not presented");

endmodule

// File: sv/ptct_dp.sv
`timescale 1ns / 1ps
module ptct_dp (
	input  logic clk,
	input  logic arst_n,
	input  ptct_pkg::cmd_t cmd,
	output ptct_pkg::status_t status,
	input  ptct_pkg::req_t req,
	input  logic [ptct_pkg::PERIOD_W-1:0] tick_period,
	input  logic tick_enable,
	output ptct_pkg::rsp_t rsp
);
	import ptct_pkg::*;

	logic func_q;
	logic [COUNT_W-1:0] sample_q;
	logic [COUNT_W-1:0] base_q;
	logic [COUNT_W-1:0] compare_q;
	logic [DVD_W-1:0] dvd_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	kind_t kind_q;
	rsp_t rsp_q;

	logic [COUNT_W-1:0] diff;
	logic diff_pos;
	kind_t kind_d;
	logic [PERIOD_W:0] rem_shift;
	logic rem_ge;
	logic [PERIOD_W:0] rem_sub;
	logic [COUNT_W-1:0] adv_compare;
	logic q_sat;

	// Classify the request from the wrap-aware difference
	assign diff = sample_q - compare_q;
	assign diff_pos = (diff != '0) && !diff[COUNT_W-1];

	always_comb begin
		if (func_q == FUNC_ARM) begin
			kind_d = K_ARM;
		end else if (!tick_enable || !diff_pos) begin
			kind_d = K_NONE;
		end else if (tick_period == '0) begin
			kind_d = K_ZERO;
		end else begin
			kind_d = K_DIV;
		end
	end

	// Restoring divide step: one quotient bit per cycle
	assign rem_shift = {rem_q, dvd_q[DVD_W-1]};
	assign rem_ge = rem_shift >= {1'b0, tick_period};
	assign rem_sub = rem_shift - {1'b0, tick_period};

	// compare + (q + 1) * period equals sample + period - remainder
	assign adv_compare = base_q - {{(COUNT_W-PERIOD_W){1'b0}}, rem_q};
	assign q_sat = (|dvd_q[DVD_W-1:TICK_W]) || (&dvd_q[TICK_W-1:0]);

	assign status.divide = (kind_q == K_DIV);
	assign status.div_last = (cnt_q == CNT_W'(DVD_W - 1));
	assign rsp = rsp_q;

	// Hold architectural state and control marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_q <= '0;
			kind_q <= K_NONE;
		end else begin
			if (cmd.eval) kind_q <= kind_d;
			if (cmd.finish) begin
				case (kind_q)
					K_ARM: compare_q <= base_q;
					K_DIV: compare_q <= adv_compare;
					default: compare_q <= compare_q;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= req.func;
			sample_q <= req.count_sample;
		end
		if (cmd.eval) begin
			base_q <= sample_q + {{(COUNT_W-PERIOD_W){1'b0}}, tick_period};
			dvd_q <= diff[DVD_W-1:0];
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], rem_ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.finish) begin
			case (kind_q)
				K_ARM: rsp_q <= '{tick_count: '0, tick_saturated: 1'b0, next_compare: base_q};
				K_ZERO: rsp_q <= '{tick_count: '1, tick_saturated: 1'b1,
					next_compare: compare_q};
				K_DIV: rsp_q <= '{tick_count: q_sat ? '1 : dvd_q[TICK_W-1:0] + TICK_W'(1),
					tick_saturated: q_sat, next_compare: adv_compare};
				default: rsp_q <= '{tick_count: '0, tick_saturated: 1'b0,
					next_compare: compare_q};
			endcase
		end
	end

	a_rem_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < tick_period)
		else $error("divider remainder out of range");

	a_arm_no_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && kind_q == K_ARM |=> rsp.tick_count == '0 && !rsp.tick_saturated)
		else $error("arm reported ticks");

	a_sat_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !rsp.tick_saturated || rsp.tick_count == '1)
		else $error("saturated result without full count");

endmodule

// File: sv/polled_tick_catchup_timer_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   ptct_pkg::req_t (func, count_sample)
// rsp       out        rsp_valid / rsp_ready   ptct_pkg::rsp_t (tick_count, tick_saturated,
//                                              next_compare)
// apb       in         psel / penable / pready tick_period @0x0, tick_enable @0x4
//
// A poll that produces ticks with a nonzero tick_period is classified, then steps through
// the one-bit-per-cycle restoring divider, then finishes. The next request can be taken in
// the cycle after the finish. Arms, polls without ticks and polls with a zero tick_period
// skip the divide steps (the divider state is passed through once).
// Reset clears the compare value to zero, tick_period to 1000000 and tick_enable to 0.
// A stalled result sits in the output register; the next request is taken meanwhile
// and its result waits in the finish step until the register frees.
module polled_tick_catchup_timer_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  ptct_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output ptct_pkg::rsp_t rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ptct_pkg::ADDR_W-1:0] paddr,
	input  logic [ptct_pkg::DATA_W-1:0] pwdata,
	output logic [ptct_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import ptct_pkg::*;

	logic [PERIOD_W-1:0] tick_period_q;
	logic tick_enable_q;
	logic reg_idx;
	cmd_t cmd;
	status_t status;

	assign pready = 1'b1;
	assign reg_idx = paddr[2];

	// Write configuration registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q <= PERIOD_RESET;
			tick_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_PERIOD: tick_period_q <= pwdata[PERIOD_W-1:0];
				REG_ENABLE: tick_enable_q <= pwdata[0];
				default: tick_enable_q <= tick_enable_q;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_PERIOD: prdata = DATA_W'(tick_period_q);
			REG_ENABLE: prdata = DATA_W'(tick_enable_q);
			default: prdata = '0;
		endcase
	end

	ptct_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.cmd(cmd)
	);

	ptct_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.req(req),
		.tick_period(tick_period_q),
		.tick_enable(tick_enable_q),
		.rsp(rsp)
	);

endmodule
